### rtl/assert_macros.svh
// Assertion helpers for the RTL files; the datapath (cpjd_dp.sv) uses them.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CPJD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define CPJD_NEVER(lbl, cond, msg) \
  `CPJD_ASSERT(lbl, !(cond), msg)

`endif

### rtl/cpjd_pkg.sv
`default_nettype none

package cpjd_pkg;

  // Default sizes of the pool, the task queue and the statistics counters
  localparam int MAX_CORES_DEF  = 8;
  localparam int FIFO_SLOTS_DEF = 16;
  localparam int COUNT_BITS_DEF = 32;

  // Field widths
  localparam int NEED_W    = 3;
  localparam int MASK_W    = 8;
  localparam int MASK_IW   = 3;
  localparam int AGE_W     = 32;
  localparam int TOTAL_W   = 4;
  localparam int DEPTH_W   = 5;
  localparam int CORE_OW   = 4;
  localparam int JOB_OW    = 4;
  localparam int WAIT_OW   = 5;
  localparam int UNFIN_OW  = 5;
  localparam int STAT_OW   = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_CORES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_DEPTH = 1'd1;

  // Register values after reset (before clamping to the configured sizes)
  localparam int TOTAL_CORES_RST = 8;
  localparam int QUEUE_DEPTH_RST = 3;

  typedef struct packed {
    logic              task_arrives;
    logic [NEED_W-1:0] task_cores;
    logic [MASK_W-1:0] finish_mask;
  } in_item_t;

  typedef struct packed {
    logic [CORE_OW-1:0]  free_core_count;
    logic [JOB_OW-1:0]   running_count;
    logic [WAIT_OW-1:0]  waiting_count;
    logic [UNFIN_OW-1:0] unfinished_count;
    logic [STAT_OW-1:0]  arrived_total;
    logic [STAT_OW-1:0]  ignored_total;
    logic [STAT_OW-1:0]  completed_total;
    logic [STAT_OW-1:0]  idle_total;
    logic [STAT_OW-1:0]  run_time_sum;
    logic [STAT_OW-1:0]  busy_core_sum;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // latch the tick, handle the arrival
    logic walk_step;  // retire or age one running job
    logic walk_done;  // commit the compacted job list
    logic dispatch;   // move the queue head onto the job list
    logic stat;       // accumulate busy cores and idle ticks
    logic load;       // capture the result register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic walk_end;   // every running job has been visited
    logic disp_ok;    // queue head fits (valid in the dispatch state)
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/cpjd_stream_if.sv
`default_nettype none

// Valid/ready channel; one transfer per edge with valid and ready high
interface cpjd_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core_pool_job_dispatcher_top.sv
// Core pool job dispatcher: one input transfer is one tick, one result per tick.
// A tick runs as follows: after the input transfer, the job walk visits each job running at
// the start of the tick and then closes the list; each dispatched task takes a queue read
// and a fit check, and one final read and check ends the dispatch. The statistics step
// follows, then the result is registered, waiting while the previous result is still held.
// Input is taken again once the result has been registered.
// Reset: counters and queue empty, 8 free cores, queue depth 3; no clearing pass.
`default_nettype none

module core_pool_job_dispatcher_top #(
  parameter int MAX_CORES  = cpjd_pkg::MAX_CORES_DEF,
  parameter int FIFO_SLOTS = cpjd_pkg::FIFO_SLOTS_DEF,
  parameter int COUNT_BITS = cpjd_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cpjd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cpjd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  cpjd_stream_if.sink                     in_i,
  cpjd_stream_if.source                   out_o
);
  import cpjd_pkg::*;

  dp_cmd_t   cmd;
  dp_stat_t  stat;
  out_item_t out_data;
  logic      in_ready;
  logic      out_valid;

  cpjd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid)
  );

  cpjd_dp #(
    .MAX_CORES  (MAX_CORES),
    .FIFO_SLOTS (FIFO_SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_i.data),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

endmodule

`default_nettype wire

### rtl/cpjd_ctrl.sv
`default_nettype none

module cpjd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_ready_i,
  input  cpjd_pkg::dp_stat_t stat_i,
  output cpjd_pkg::dp_cmd_t  cmd_o,
  output logic               in_ready_o,
  output logic               out_valid_o
);
  import cpjd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_DISP  = 3'd3;
  localparam logic [2:0] S_STAT  = 3'd4;
  localparam logic [2:0] S_LOAD  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Sequencing of one tick
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_WALK;
        end
      end
      S_WALK: begin
        if (stat_i.walk_end) begin
          cmd_o.walk_done = 1'b1;
          state_d         = S_FETCH;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      // head entry is read from the queue memory here
      S_FETCH: begin
        state_d = S_DISP;
      end
      S_DISP: begin
        if (stat_i.disp_ok) begin
          cmd_o.dispatch = 1'b1;
          state_d        = S_FETCH;
        end else begin
          state_d = S_STAT;
        end
      end
      S_STAT: begin
        cmd_o.stat = 1'b1;
        state_d    = S_LOAD;
      end
      S_LOAD: begin
        // wait until the previous result has been taken
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### rtl/cpjd_dp.sv
`default_nettype none
`include "assert_macros.svh"

module cpjd_dp #(
  parameter int MAX_CORES  = cpjd_pkg::MAX_CORES_DEF,
  parameter int FIFO_SLOTS = cpjd_pkg::FIFO_SLOTS_DEF,
  parameter int COUNT_BITS = cpjd_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cpjd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cpjd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  cpjd_pkg::in_item_t              in_data_i,
  input  cpjd_pkg::dp_cmd_t               cmd_i,
  output cpjd_pkg::dp_stat_t              stat_o,
  output cpjd_pkg::out_item_t             out_data_o
);
  import cpjd_pkg::*;

  // core counts, job counts, job index
  localparam int CW = $clog2(MAX_CORES + 1);
  localparam int JW = CW;
  localparam int IW = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  // queue fill and pointer
  localparam int FW = $clog2(FIFO_SLOTS + 1);
  localparam int PW = $clog2(FIFO_SLOTS);
  // sums
  localparam int RW = CW + NEED_W;
  localparam int UW = ((JW > FW) ? JW : FW) + 1;
  localparam int AW = (COUNT_BITS > AGE_W) ? COUNT_BITS : AGE_W;
  localparam int SW = AW + 1;
  localparam int TC_RST = (TOTAL_CORES_RST > MAX_CORES) ? MAX_CORES : TOTAL_CORES_RST;
  localparam int QD_RST = (QUEUE_DEPTH_RST > FIFO_SLOTS) ? FIFO_SLOTS : QUEUE_DEPTH_RST;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] cur,
                                                    input logic [AW-1:0]         amt);
    logic [SW-1:0] sum;
    sum = SW'(cur) + SW'(amt);
    return (sum > SW'(CNT_MAX)) ? CNT_MAX : COUNT_BITS'(sum);
  endfunction

  // Configuration and pool state
  logic [CW-1:0] total_q, total_d;
  logic [FW-1:0] depth_q, depth_d;
  logic [CW-1:0] free_q, free_d;
  logic [CW-1:0] busy_q, busy_d;        // cores held by running jobs
  logic [JW-1:0] job_count_q, job_count_d;
  logic [JW-1:0] idx_q, idx_d;
  logic [JW-1:0] kept_q, kept_d;
  logic [PW-1:0] head_q, head_d;
  logic [FW-1:0] fill_q, fill_d;

  // Statistics
  logic [COUNT_BITS-1:0] arrived_q, arrived_d;
  logic [COUNT_BITS-1:0] ignored_q, ignored_d;
  logic [COUNT_BITS-1:0] completed_q, completed_d;
  logic [COUNT_BITS-1:0] idle_q, idle_d;
  logic [COUNT_BITS-1:0] runtime_q, runtime_d;
  logic [COUNT_BITS-1:0] busysum_q, busysum_d;

  // Payload storage
  logic [NEED_W-1:0] job_need_q [MAX_CORES];
  logic [AGE_W-1:0]  job_age_q  [MAX_CORES];
  logic [NEED_W-1:0] fifo_mem   [FIFO_SLOTS];
  logic [NEED_W-1:0] rd_data_q;
  logic [MASK_W-1:0] mask_q;
  out_item_t         out_q;

  // Combinational helpers
  logic [TOTAL_W-1:0] tc_raw;
  logic [CW-1:0]      tc_cl;
  logic [DEPTH_W-1:0] qd_raw;
  logic [FW-1:0]      qd_cl;
  logic               reject;
  logic [FW:0]        tail_sum;
  logic               fifo_we;
  logic [PW-1:0]      fifo_waddr;
  logic [NEED_W-1:0]  rd_need;
  logic [AGE_W-1:0]   rd_age;
  logic               done;
  logic [RW-1:0]      ret_sum;
  logic               job_we;
  logic [IW-1:0]      job_waddr;
  logic [NEED_W-1:0]  job_wneed;
  logic [AGE_W-1:0]   job_wage;
  logic [CW-1:0]      busy_amt;
  logic [UW-1:0]      unfin;

  // Register clamping
  assign tc_raw = cfg_data_i[TOTAL_W-1:0];
  assign qd_raw = cfg_data_i[DEPTH_W-1:0];
  always_comb begin
    if (tc_raw == '0) begin
      tc_cl = CW'(1);
    end else if (tc_raw > MAX_CORES) begin
      tc_cl = CW'(MAX_CORES);
    end else begin
      tc_cl = CW'(tc_raw);
    end
    if (qd_raw == '0) begin
      qd_cl = FW'(1);
    end else if (qd_raw > FIFO_SLOTS) begin
      qd_cl = FW'(FIFO_SLOTS);
    end else begin
      qd_cl = FW'(qd_raw);
    end
  end

  // Arrival check and queue tail
  assign reject = (in_data_i.task_cores == '0) || (in_data_i.task_cores > total_q) ||
                  (fill_q >= depth_q) || (fill_q >= FIFO_SLOTS);
  assign tail_sum = (FW+1)'(head_q) + (FW+1)'(fill_q);
  assign fifo_waddr = (tail_sum >= FIFO_SLOTS) ? PW'(tail_sum - (FW+1)'(FIFO_SLOTS))
                                               : PW'(tail_sum);
  assign fifo_we = cmd_i.accept && in_data_i.task_arrives && !reject;

  // Job visited by the walk
  assign rd_need  = job_need_q[idx_q[IW-1:0]];
  assign rd_age   = job_age_q[idx_q[IW-1:0]];
  assign done     = (idx_q < MASK_W) && mask_q[MASK_IW'(idx_q)];
  assign ret_sum  = RW'(free_q) + RW'(rd_need);
  assign busy_amt = (total_q > free_q) ? total_q - free_q : '0;
  assign unfin    = UW'(job_count_q) + UW'(fill_q);

  // Status
  assign stat_o.walk_end = (idx_q >= job_count_q);
  assign stat_o.disp_ok  = (fill_q != '0) && (job_count_q < MAX_CORES) &&
                           (rd_data_q <= free_q);

  // Next state
  always_comb begin
    total_d     = total_q;
    depth_d     = depth_q;
    free_d      = free_q;
    busy_d      = busy_q;
    job_count_d = job_count_q;
    idx_d       = idx_q;
    kept_d      = kept_q;
    head_d      = head_q;
    fill_d      = fill_q;
    arrived_d   = arrived_q;
    ignored_d   = ignored_q;
    completed_d = completed_q;
    idle_d      = idle_q;
    runtime_d   = runtime_q;
    busysum_d   = busysum_q;
    job_we      = 1'b0;
    job_waddr   = kept_q[IW-1:0];
    job_wneed   = rd_need;
    job_wage    = (&rd_age) ? rd_age : rd_age + 1'b1;

    // configuration write; free cores follow a new pool size
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TOTAL_CORES: begin
          total_d = tc_cl;
          free_d  = (tc_cl > busy_q) ? tc_cl - busy_q : '0;
        end
        CFG_QUEUE_DEPTH: begin
          depth_d = qd_cl;
        end
        default: begin
        end
      endcase
    end

    // arrival
    if (cmd_i.accept) begin
      idx_d  = '0;
      kept_d = '0;
      if (in_data_i.task_arrives) begin
        arrived_d = sat_inc(arrived_q);
        if (reject) begin
          ignored_d = sat_inc(ignored_q);
        end else begin
          fill_d = fill_q + 1'b1;
        end
      end
    end

    // one job: retire it or move it down and age it
    if (cmd_i.walk_step) begin
      idx_d = idx_q + 1'b1;
      if (done) begin
        free_d      = (ret_sum > RW'(total_q)) ? total_q : CW'(ret_sum);
        busy_d      = busy_q - CW'(rd_need);
        runtime_d   = sat_add(runtime_q, AW'(rd_age));
        completed_d = sat_inc(completed_q);
      end else begin
        job_we = 1'b1;
        kept_d = kept_q + 1'b1;
      end
    end

    if (cmd_i.walk_done) begin
      job_count_d = kept_q;
    end

    // head task starts at age one
    if (cmd_i.dispatch) begin
      job_we      = 1'b1;
      job_waddr   = job_count_q[IW-1:0];
      job_wneed   = rd_data_q;
      job_wage    = AGE_W'(1);
      free_d      = free_q - CW'(rd_data_q);
      busy_d      = busy_q + CW'(rd_data_q);
      job_count_d = job_count_q + 1'b1;
      head_d      = (head_q == PW'(FIFO_SLOTS - 1)) ? '0 : head_q + 1'b1;
      fill_d      = fill_q - 1'b1;
    end

    if (cmd_i.stat) begin
      busysum_d = sat_add(busysum_q, AW'(busy_amt));
      if (job_count_q == '0) begin
        idle_d = sat_inc(idle_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= CW'(TC_RST);
      depth_q     <= FW'(QD_RST);
      free_q      <= CW'(TC_RST);
      busy_q      <= '0;
      job_count_q <= '0;
      idx_q       <= '0;
      kept_q      <= '0;
      head_q      <= '0;
      fill_q      <= '0;
      arrived_q   <= '0;
      ignored_q   <= '0;
      completed_q <= '0;
      idle_q      <= '0;
      runtime_q   <= '0;
      busysum_q   <= '0;
    end else begin
      total_q     <= total_d;
      depth_q     <= depth_d;
      free_q      <= free_d;
      busy_q      <= busy_d;
      job_count_q <= job_count_d;
      idx_q       <= idx_d;
      kept_q      <= kept_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      arrived_q   <= arrived_d;
      ignored_q   <= ignored_d;
      completed_q <= completed_d;
      idle_q      <= idle_d;
      runtime_q   <= runtime_d;
      busysum_q   <= busysum_d;
    end
  end

  // Task queue memory, head read registered
  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_mem[fifo_waddr] <= in_data_i.task_cores;
    end
    rd_data_q <= fifo_mem[head_q];
  end

  // Job list
  always_ff @(posedge clk_i) begin
    if (job_we) begin
      job_need_q[job_waddr] <= job_wneed;
      job_age_q[job_waddr]  <= job_wage;
    end
  end

  // Tick payload and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mask_q <= in_data_i.finish_mask;
    end
    if (cmd_i.load) begin
      out_q.free_core_count  <= CORE_OW'(free_q);
      out_q.running_count    <= JOB_OW'(job_count_q);
      out_q.waiting_count    <= WAIT_OW'(fill_q);
      out_q.unfinished_count <= UNFIN_OW'(unfin);
      out_q.arrived_total    <= STAT_OW'(arrived_q);
      out_q.ignored_total    <= STAT_OW'(ignored_q);
      out_q.completed_total  <= STAT_OW'(completed_q);
      out_q.idle_total       <= STAT_OW'(idle_q);
      out_q.run_time_sum     <= STAT_OW'(runtime_q);
      out_q.busy_core_sum    <= STAT_OW'(busysum_q);
    end
  end

  assign out_data_o = out_q;

  // Checks
  `CPJD_ASSERT(a_free_le_total, free_q <= total_q, "free cores exceed pool size")
  `CPJD_ASSERT(a_busy_bound, busy_q <= MAX_CORES, "held cores exceed pool limit")
  `CPJD_NEVER(a_fill_bound, fill_q > FIFO_SLOTS, "queue fill beyond its slots")
  `CPJD_ASSERT(a_disp_grows, cmd_i.dispatch |=> (job_count_q == $past(job_count_q) + 1'b1),
               "dispatch did not add a job")

endmodule

`default_nettype wire

### tb/job_dispatch_checker.sv
`timescale 1ns / 1ps

// Watches the config port and both channels. Keeps its own model of the pool
// and the task queue, and checks every tick result against it.
module job_dispatch_checker
  import cpjd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_item_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_item_t             out_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam int JOB_SLOTS  = MAX_CORES_DEF;
  localparam int QUEUE_SLOTS = FIFO_SLOTS_DEF;
  localparam logic [STAT_OW-1:0] STAT_MAX = '1;

  // Pool and queue model
  int                pool_size;
  int                queue_limit;
  int                avail_cores;
  logic [NEED_W-1:0] job_need [JOB_SLOTS];
  logic [AGE_W-1:0]  job_age  [JOB_SLOTS];
  int                job_cnt;
  logic [NEED_W-1:0] wait_need [QUEUE_SLOTS];
  int                wait_head;
  int                wait_fill;

  // Statistics model
  logic [STAT_OW-1:0] arrived_cnt, ignored_cnt, completed_cnt;
  logic [STAT_OW-1:0] idle_cnt, run_time_acc, busy_core_acc;

  out_item_t tick_results_q[$];
  int        mismatches;

  function automatic logic [STAT_OW-1:0] sat_add(input logic [STAT_OW-1:0] cur,
                                                 input longint unsigned amount);
    longint unsigned sum;
    sum = longint'(cur) + amount;
    return (sum > longint'(STAT_MAX)) ? STAT_MAX : sum[STAT_OW-1:0];
  endfunction

  task automatic reset_pool();
    pool_size   = TOTAL_CORES_RST;
    queue_limit = QUEUE_DEPTH_RST;
    avail_cores = pool_size;
    job_cnt     = 0;
    wait_head   = 0;
    wait_fill   = 0;
    arrived_cnt   = '0;
    ignored_cnt   = '0;
    completed_cnt = '0;
    idle_cnt      = '0;
    run_time_acc  = '0;
    busy_core_acc = '0;
    mismatches  = 0;
    tick_results_q.delete();
  endtask

  // Register write: clamp, and rebase free cores on a new pool size
  task automatic apply_setting(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] value);
    int v;
    int held;
    case (idx)
      CFG_TOTAL_CORES: begin
        v = value[TOTAL_W-1:0];
        if (v < 1) v = 1;
        if (v > JOB_SLOTS) v = JOB_SLOTS;
        pool_size = v;
        held = 0;
        for (int j = 0; j < job_cnt; j++) held += job_need[j];
        avail_cores = (v > held) ? v - held : 0;
      end
      CFG_QUEUE_DEPTH: begin
        v = value[DEPTH_W-1:0];
        if (v < 1) v = 1;
        if (v > QUEUE_SLOTS) v = QUEUE_SLOTS;
        queue_limit = v;
      end
      default: ;
    endcase
  endtask

  // One tick: arrival, completions and aging, dispatch, statistics
  function automatic out_item_t advance_tick(input in_item_t t);
    out_item_t r;
    int        kept;
    int        head_need;
    if (t.task_arrives) begin
      arrived_cnt = sat_add(arrived_cnt, 1);
      if (t.task_cores == 0 || t.task_cores > pool_size || wait_fill >= queue_limit) begin
        ignored_cnt = sat_add(ignored_cnt, 1);
      end else begin
        wait_need[(wait_head + wait_fill) % QUEUE_SLOTS] = t.task_cores;
        wait_fill++;
      end
    end

    // retire marked jobs, age the rest, close up the list
    kept = 0;
    for (int j = 0; j < job_cnt; j++) begin
      if (t.finish_mask[j]) begin
        avail_cores += job_need[j];
        if (avail_cores > pool_size) avail_cores = pool_size;
        run_time_acc  = sat_add(run_time_acc, job_age[j]);
        completed_cnt = sat_add(completed_cnt, 1);
      end else begin
        job_need[kept] = job_need[j];
        job_age[kept]  = (job_age[j] == '1) ? job_age[j] : job_age[j] + 1'b1;
        kept++;
      end
    end
    job_cnt = kept;

    // start queued tasks in order while the head fits
    while (wait_fill > 0 && job_cnt < JOB_SLOTS) begin
      head_need = wait_need[wait_head];
      if (head_need > avail_cores) break;
      avail_cores -= head_need;
      job_need[job_cnt] = head_need[NEED_W-1:0];
      job_age[job_cnt]  = 1;
      job_cnt++;
      wait_head = (wait_head + 1) % QUEUE_SLOTS;
      wait_fill--;
    end

    busy_core_acc = sat_add(busy_core_acc,
                            (pool_size > avail_cores) ? pool_size - avail_cores : 0);
    if (job_cnt == 0) idle_cnt = sat_add(idle_cnt, 1);

    r.free_core_count  = avail_cores[CORE_OW-1:0];
    r.running_count    = job_cnt[JOB_OW-1:0];
    r.waiting_count    = wait_fill[WAIT_OW-1:0];
    r.unfinished_count = 5'(job_cnt + wait_fill);
    r.arrived_total    = arrived_cnt;
    r.ignored_total    = ignored_cnt;
    r.completed_total  = completed_cnt;
    r.idle_total       = idle_cnt;
    r.run_time_sum     = run_time_acc;
    r.busy_core_sum    = busy_core_acc;
    return r;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare first, then queue the new tick: a result can never belong to
  // a tick transferred on the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    out_item_t fresh;
    if (!rst_ni) begin
      reset_pool();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) apply_setting(cfg_index_i, cfg_data_i);

      if (out_valid_i && out_ready_i) begin
        if (tick_results_q.size() == 0) begin
          $display("%0t: tick result with nothing expected, actual %p", $time, out_data_i);
          mismatches++;
        end else begin
          want = tick_results_q.pop_front();
          check_field("free_core_count",  want.free_core_count,  out_data_i.free_core_count);
          check_field("running_count",    want.running_count,    out_data_i.running_count);
          check_field("waiting_count",    want.waiting_count,    out_data_i.waiting_count);
          check_field("unfinished_count", want.unfinished_count, out_data_i.unfinished_count);
          check_field("arrived_total",    want.arrived_total,    out_data_i.arrived_total);
          check_field("ignored_total",    want.ignored_total,    out_data_i.ignored_total);
          check_field("completed_total",  want.completed_total,  out_data_i.completed_total);
          check_field("idle_total",       want.idle_total,       out_data_i.idle_total);
          check_field("run_time_sum",     want.run_time_sum,     out_data_i.run_time_sum);
          check_field("busy_core_sum",    want.busy_core_sum,    out_data_i.busy_core_sum);
        end
      end

      if (in_valid_i && in_ready_i) begin
        fresh = advance_tick(in_data_i);
        tick_results_q.insert(tick_results_q.size(), fresh);
      end

      fail_count_o <= mismatches;
      pending_o    <= tick_results_q.size();
    end
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import cpjd_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_TICKS = 1950;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;
  int                    cycle_cnt = 0;
  bit                    quiet;

  cpjd_stream_if #(.T(in_item_t))  in_if ();
  cpjd_stream_if #(.T(out_item_t)) out_if ();

  core_pool_job_dispatcher_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  job_dispatch_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_if.valid),
    .in_ready_i   (in_if.ready),
    .in_data_i    (in_if.data),
    .out_valid_i  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .out_data_i   (out_if.data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: random stalls between transfers unless in a quiet phase
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  // One tick transfer, after a random gap
  task automatic send_tick(input logic arrives, input logic [NEED_W-1:0] cores,
                           input logic [MASK_W-1:0] mask);
    in_item_t t;
    int       gap;
    t.task_arrives = arrives;
    t.task_cores   = cores;
    t.finish_mask  = mask;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= t;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Hold off input until every result is back, then wait the given extra cycles
  task automatic drain(input int extra);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic program_pool(input logic [CFG_DATA_W-1:0] cores,
                              input logic [CFG_DATA_W-1:0] depth);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TOTAL_CORES;
    cfg_data  <= cores;
    @(posedge clk_i);
    cfg_index <= CFG_QUEUE_DEPTH;
    cfg_data  <= depth;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int                    random_sent;
    int                    phase_len;
    int                    arrive_pct;
    int                    finish_pct;
    logic [CFG_DATA_W-1:0] new_cores;
    logic [CFG_DATA_W-1:0] new_depth;
    logic                  arrives;
    logic [NEED_W-1:0]     cores;
    logic [MASK_W-1:0]     mask;

    random_sent = 0;
    quiet       = 1'b0;
    rst_ni      <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_TOTAL_CORES;
    cfg_data    <= '0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: 8 cores, queue of 3
    send_tick(1'b1, 3'd1, 8'h00);
    send_tick(1'b1, 3'd4, 8'h00);
    send_tick(1'b1, 3'd4, 8'h00);  // head blocks, queue fills
    send_tick(1'b1, 3'd4, 8'h00);
    send_tick(1'b1, 3'd2, 8'h00);
    send_tick(1'b1, 3'd1, 8'h00);  // queue full
    send_tick(1'b1, 3'd0, 8'h00);  // zero-core task
    send_tick(1'b0, 3'd0, 8'hFF);  // all done, extra mask bits ignored
    send_tick(1'b0, 3'd5, 8'h02);
    send_tick(1'b1, 3'd3, 8'h00);

    // Shrink the pool below what running jobs hold; depth above range
    drain(4);
    program_pool(5'd0, 5'd31);
    send_tick(1'b1, 3'd2, 8'h00);  // oversized
    send_tick(1'b1, 3'd7, 8'h00);
    send_tick(1'b1, 3'd1, 8'h01);  // returned cores capped at pool size
    send_tick(1'b0, 3'd0, 8'h01);

    // Pool above range, depth below the queued count
    drain(4);
    program_pool(5'd15, 5'd0);
    send_tick(1'b1, 3'd1, 8'h00);
    repeat (5) send_tick(1'b1, 3'd1, 8'h00);
    send_tick(1'b0, 3'd0, 8'h01);
    send_tick(1'b1, 3'd1, 8'h00);
    send_tick(1'b1, 3'd1, 8'h00);  // job list full
    send_tick(1'b1, 3'd1, 8'h00);
    send_tick(1'b0, 3'd0, 8'h80);

    // Random phases, each with its own settings, load and idling
    while (random_sent < RANDOM_TICKS) begin
      drain(4);
      case ($urandom_range(0, 7))
        0:       new_cores = 5'd0;
        1:       new_cores = 5'd1;
        2:       new_cores = 5'd8;
        3:       new_cores = 5'd15;
        4:       new_cores = CFG_DATA_W'($urandom_range(0, 31));
        default: new_cores = CFG_DATA_W'($urandom_range(2, 8));
      endcase
      case ($urandom_range(0, 7))
        0:       new_depth = 5'd0;
        1:       new_depth = 5'd1;
        2:       new_depth = 5'd16;
        3:       new_depth = 5'd31;
        4:       new_depth = CFG_DATA_W'($urandom_range(0, 31));
        default: new_depth = CFG_DATA_W'($urandom_range(2, 16));
      endcase
      program_pool(new_cores, new_depth);

      quiet      = ($urandom_range(0, 3) == 0);
      phase_len  = $urandom_range(20, 120);
      arrive_pct = $urandom_range(30, 95);
      case ($urandom_range(0, 3))
        0:       finish_pct = 5;
        1:       finish_pct = 15;
        2:       finish_pct = 30;
        default: finish_pct = 60;
      endcase

      repeat (phase_len) begin
        arrives = ($urandom_range(0, 99) < arrive_pct);
        if ($urandom_range(0, 9) == 0) cores = NEED_W'($urandom_range(0, 7));
        else                           cores = NEED_W'($urandom_range(1, 4));
        case ($urandom_range(0, 19))
          0:       mask = 8'hFF;
          1:       mask = MASK_W'($urandom_range(0, 255));
          default: begin
            for (int b = 0; b < MASK_W; b++) mask[b] = ($urandom_range(0, 99) < finish_pct);
          end
        endcase
        send_tick(arrives, cores, mask);
        random_sent++;
      end
    end

    quiet = 1'b0;
    drain(40);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
